// ----- hdl/rc4d_pkg.sv -----
// Package for the chunked RC4 stream decryptor.
// Holds payload types, controller/datapath interface structs, state and register codes.
// No dependencies.
`default_nettype none

package rc4d_pkg;

  localparam int CHUNK_BYTES = 512;
  localparam int POS_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(CHUNK_BYTES - 1);

  localparam int PERM_DEPTH = 256;
  localparam int BYTE_W = 8;
  localparam int KEY_W = 64;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd2;

  localparam logic KEY_ENABLE_RST = 1'b1;
  localparam logic [KEY_W-1:0] KEY_LOW_RST = 64'h0709055504034E7C;
  localparam logic [KEY_W-1:0] KEY_HIGH_RST = 64'h11170D17387B2C2D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD_A,
    ST_KS_RD_J,
    ST_KS_WR_A,
    ST_KS_WR_J,
    ST_GEN_RD_I,
    ST_GEN_RD_J,
    ST_GEN_WR_I,
    ST_GEN_WR_J,
    ST_GEN_RD_T,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic fill;
    logic ks_rd_a;
    logic ks_rd_j;
    logic ks_wr_a;
    logic ks_wr_j;
    logic gen_rd_i;
    logic gen_rd_j;
    logic gen_wr_i;
    logic gen_wr_j;
    logic gen_rd_t;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic chunk_start;
    logic enable;
    logic cnt_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/rc4d_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
`default_nettype none

module rc4d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rc4d_ctrl.sv -----
// Controller state machine for the chunked RC4 stream decryptor.
// Sequences re-key, keystream generation and result hand-off; uses rc4d_pkg.
`default_nettype none

module rc4d_ctrl
  import rc4d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.chunk_start) begin
            state_next = ST_FILL;
          end else if (sts.enable) begin
            state_next = ST_GEN_RD_I;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_FILL: begin
        if (sts.cnt_last) begin
          state_next = ST_KS_RD_A;
        end
      end
      ST_KS_RD_A: state_next = ST_KS_RD_J;
      ST_KS_RD_J: state_next = ST_KS_WR_A;
      ST_KS_WR_A: state_next = ST_KS_WR_J;
      ST_KS_WR_J: begin
        if (!sts.cnt_last) begin
          state_next = ST_KS_RD_A;
        end else if (sts.enable) begin
          state_next = ST_GEN_RD_I;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_GEN_RD_I: state_next = ST_GEN_RD_J;
      ST_GEN_RD_J: state_next = ST_GEN_WR_I;
      ST_GEN_WR_I: state_next = ST_GEN_WR_J;
      ST_GEN_WR_J: state_next = ST_GEN_RD_T;
      ST_GEN_RD_T: state_next = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_FILL:     cmd.fill = 1'b1;
      ST_KS_RD_A:  cmd.ks_rd_a = 1'b1;
      ST_KS_RD_J:  cmd.ks_rd_j = 1'b1;
      ST_KS_WR_A:  cmd.ks_wr_a = 1'b1;
      ST_KS_WR_J:  cmd.ks_wr_j = 1'b1;
      ST_GEN_RD_I: cmd.gen_rd_i = 1'b1;
      ST_GEN_RD_J: cmd.gen_rd_j = 1'b1;
      ST_GEN_WR_I: cmd.gen_wr_i = 1'b1;
      ST_GEN_WR_J: cmd.gen_wr_j = 1'b1;
      ST_GEN_RD_T: cmd.gen_rd_t = 1'b1;
      ST_EMIT:     cmd.emit = sts.out_free;
      default:     cmd = '0;
    endcase
  end

  a_rekey_on_chunk_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && sts.chunk_start) |=> state == ST_FILL)
    else $error("chunk start did not begin re-key");

  a_ks_ends_on_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KS_WR_J && sts.cnt_last) |=> state != ST_KS_RD_A)
    else $error("key schedule ran past its last step");

  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !sts.out_free) |=> state == ST_EMIT)
    else $error("result dropped while output busy");

endmodule

`default_nettype wire

// ----- hdl/rc4d_datapath.sv -----
// Datapath for the chunked RC4 stream decryptor: config registers, RC4 indexes,
// permutation table RAM, chunk position and output register; uses rc4d_pkg, rc4d_ram.
`default_nettype none

module rc4d_datapath
  import rc4d_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire in_item_t              in_data,
  output out_item_t                  out_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire cmd_t                  cmd,
  output sts_t                       sts
);

  logic             enable;
  logic [KEY_W-1:0] key_low;
  logic [KEY_W-1:0] key_high;
  in_item_t         in_reg;
  logic [7:0]       cnt;
  logic [7:0]       kj;
  logic [7:0]       idx_i;
  logic [7:0]       idx_j;
  logic [7:0]       sa;
  logic [7:0]       sb;
  logic [POS_W-1:0] pos;

  logic             ram_we;
  logic [7:0]       ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [7:0]       ram_raddr;
  logic [7:0]       ram_rdata;

  logic [2*KEY_W-1:0] key_all;
  logic [7:0]         key_byte;
  logic [7:0]         kj_next;
  logic [7:0]         i_next;
  logic [7:0]         j_next;
  logic [7:0]         ks_byte;

  assign key_all = {key_high, key_low};
  assign key_byte = key_all[{cnt[3:0], 3'b000} +: 8];
  assign kj_next = kj + ram_rdata + key_byte;
  assign i_next = idx_i + 8'd1;
  assign j_next = idx_j + ram_rdata;
  assign ks_byte = enable ? ram_rdata : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= KEY_ENABLE_RST;
      key_low <= KEY_LOW_RST;
      key_high <= KEY_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DECRYPT_ENABLE: enable <= cfg_data[0];
        CFG_KEY_LOW:        key_low <= cfg_data;
        CFG_KEY_HIGH:       key_high <= cfg_data;
        default:            enable <= enable;
      endcase
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = cnt;
    ram_wdata = cnt;
    ram_re = 1'b0;
    ram_raddr = cnt;
    if (cmd.fill) begin
      ram_we = 1'b1;
    end
    if (cmd.ks_rd_a) begin
      ram_re = 1'b1;
    end
    if (cmd.ks_rd_j) begin
      ram_re = 1'b1;
      ram_raddr = kj_next;
    end
    if (cmd.ks_wr_a) begin
      ram_we = 1'b1;
      ram_wdata = ram_rdata;
    end
    if (cmd.ks_wr_j) begin
      ram_we = 1'b1;
      ram_waddr = kj;
      ram_wdata = sa;
    end
    if (cmd.gen_rd_i) begin
      ram_re = 1'b1;
      ram_raddr = i_next;
    end
    if (cmd.gen_rd_j) begin
      ram_re = 1'b1;
      ram_raddr = j_next;
    end
    if (cmd.gen_wr_i) begin
      ram_we = 1'b1;
      ram_waddr = idx_i;
      ram_wdata = ram_rdata;
    end
    if (cmd.gen_wr_j) begin
      ram_we = 1'b1;
      ram_waddr = idx_j;
      ram_wdata = sa;
    end
    if (cmd.gen_rd_t) begin
      ram_re = 1'b1;
      ram_raddr = sa + sb;
    end
  end

  rc4d_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(PERM_DEPTH)
  ) u_perm (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx_i <= '0;
      idx_j <= '0;
      pos <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.fill || cmd.ks_wr_j) begin
        cnt <= cnt + 8'd1;
      end
      if (cmd.ks_wr_j && sts.cnt_last) begin
        idx_i <= '0;
        idx_j <= '0;
      end
      if (cmd.gen_rd_i) begin
        idx_i <= i_next;
      end
      if (cmd.gen_rd_j) begin
        idx_j <= j_next;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (in_reg.last_byte || pos == POS_LAST) begin
          pos <= '0;
        end else begin
          pos <= pos + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_reg <= in_data;
    end
    if (cmd.fill) begin
      kj <= '0;
    end else if (cmd.ks_rd_j) begin
      kj <= kj_next;
    end
    if (cmd.ks_rd_j || cmd.gen_rd_j) begin
      sa <= ram_rdata;
    end
    if (cmd.gen_wr_i) begin
      sb <= ram_rdata;
    end
    if (cmd.emit) begin
      out_data.out_byte <= in_reg.data_byte ^ ks_byte;
      out_data.out_last <= in_reg.last_byte;
    end
  end

  assign sts.chunk_start = (pos == '0);
  assign sts.enable = enable;
  assign sts.cnt_last = (cnt == 8'hFF);
  assign sts.out_free = !out_valid || out_ready;

  a_no_read_on_write: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("permutation table read and written in one cycle");

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwrote a pending transfer");

  a_last_ends_chunk: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && in_reg.last_byte) |=> pos == '0)
    else $error("last byte did not end the chunk");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("output valid without a result");

endmodule

`default_nettype wire

// ----- hdl/chunked_rc4_stream_decrypt.sv -----
// Chunked RC4 stream decryptor, top level: one byte per transfer, RC4 re-keyed per chunk.
// With decryption on a byte runs ST_GEN_RD_I, ST_GEN_RD_J, ST_GEN_WR_I, ST_GEN_WR_J and
// ST_GEN_RD_T, one permutation RAM access each, then ST_EMIT; with it off, just ST_EMIT.
// A new byte is taken only after ST_EMIT, which waits on out_ready. A chunk's first byte
// re-keys first: 256 identity writes, then two reads and two writes per key schedule step.
// Reset (synchronous, rst high): idle, output empty, registers at defaults, next byte re-keys.
`default_nettype none

module chunked_rc4_stream_decrypt
  import rc4d_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  rc4d_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  rc4d_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .out_data (out_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

`default_nettype wire
